FILE: hw/rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// Password rule checker package
// Shared configuration type, register indexes, reason codes and field sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int RUN_W      = 16;
  localparam int LIMIT_W    = 16;
  localparam int ENTROPY_W  = 32;
  localparam int REASON_W   = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_CLASSES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPETITION  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEQUENCE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ENTROPY     = 3'd6;

  // Bit positions in check_enable.
  localparam int EN_MIN_LEN  = 0;
  localparam int EN_MAX_LEN  = 1;
  localparam int EN_REPEAT   = 2;
  localparam int EN_SEQUENCE = 3;

  // Bit positions in require_classes and in the seen-class flags.
  localparam int CLS_CAPITAL = 0;
  localparam int CLS_DIGIT   = 1;
  localparam int CLS_SYMBOL  = 2;

  // Bit positions in the sticky run flags.
  localparam int EXC_REPEAT   = 0;
  localparam int EXC_SEQUENCE = 1;

  // Verdict reason codes.
  localparam logic [REASON_W-1:0] R_PASS     = 4'd0;
  localparam logic [REASON_W-1:0] R_MIN_LEN  = 4'd1;
  localparam logic [REASON_W-1:0] R_MAX_LEN  = 4'd2;
  localparam logic [REASON_W-1:0] R_CAPITAL  = 4'd3;
  localparam logic [REASON_W-1:0] R_DIGIT    = 4'd4;
  localparam logic [REASON_W-1:0] R_SYMBOL   = 4'd5;
  localparam logic [REASON_W-1:0] R_REPEAT   = 4'd6;
  localparam logic [REASON_W-1:0] R_SEQUENCE = 4'd7;
  localparam logic [REASON_W-1:0] R_ENTROPY  = 4'd8;

  typedef struct packed {
    logic [3:0]           check_enable;
    logic [2:0]           require_classes;
    logic [LIMIT_W-1:0]   len_floor;
    logic [LIMIT_W-1:0]   len_ceiling;
    logic [LIMIT_W-1:0]   repeat_limit;
    logic [LIMIT_W-1:0]   climb_limit;
    logic [ENTROPY_W-1:0] entropy_floor;
  } prc_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/password_rule_checker_unit.sv
// Pipeline: a final request is held in the input stage register, and out_valid
// rises when that request moves on into the result register.
// Throughput: one request per cycle while the result register is free or drains;
// the byte update and the verdict are one level of small counters and compares between the two registers.
// Reset: synchronous, active low; clears statistics, empties both stages and
// loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Password rule checker
// Streams a password one byte per request and returns one verdict with the
// first failing check on the request marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module password_rule_checker_unit #(
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [prc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_has_char,
  input  wire logic [7:0]                        in_char_byte,
  input  wire logic                              in_is_last,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_accepted,
  output logic      [prc_pkg::REASON_W-1:0]      out_fail_reason
);
  import prc_pkg::*;

  prc_cfg_t            cfg_r;
  logic                s1_valid_r;
  logic                s1_has_r;
  logic [7:0]          s1_byte_r;
  logic                s1_last_r;
  logic                out_valid_r;
  logic                out_accepted_r;
  logic [REASON_W-1:0] out_reason_r;
  logic [REASON_W-1:0] reason;
  logic                s1_adv;
  logic                step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_enable    <= '0;
      cfg_r.require_classes <= '0;
      cfg_r.len_floor       <= '0;
      cfg_r.len_ceiling     <= '1;
      cfg_r.repeat_limit    <= '0;
      cfg_r.climb_limit     <= '0;
      cfg_r.entropy_floor   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CHECK_ENABLE:    cfg_r.check_enable    <= cfg_data[3:0];
        CFG_REQUIRE_CLASSES: cfg_r.require_classes <= cfg_data[2:0];
        CFG_MIN_LENGTH:      cfg_r.len_floor       <= cfg_data[LIMIT_W-1:0];
        CFG_MAX_LENGTH:      cfg_r.len_ceiling     <= cfg_data[LIMIT_W-1:0];
        CFG_MAX_REPETITION:  cfg_r.repeat_limit    <= cfg_data[LIMIT_W-1:0];
        CFG_MAX_SEQUENCE:    cfg_r.climb_limit     <= cfg_data[LIMIT_W-1:0];
        CFG_MIN_ENTROPY:     cfg_r.entropy_floor   <= cfg_data[ENTROPY_W-1:0];
        default: ;
      endcase
    end
  end

  // The input stage moves on whenever the result register is free or drains.
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign step     = s1_valid_r && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_has_r  <= in_has_char;
      s1_byte_r <= in_char_byte;
      s1_last_r <= in_is_last;
    end
  end

  prc_track #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step      (step),
    .has_char  (s1_has_r),
    .char_byte (s1_byte_r),
    .is_last   (s1_last_r),
    .reason    (reason)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last_r) begin
      out_reason_r   <= reason;
      out_accepted_r <= (reason == R_PASS);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_accepted_r;
  assign out_fail_reason = out_reason_r;

  a_pass_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_accepted_r == (out_reason_r == R_PASS)))
    else $error("accepted flag disagrees with reason code");

  a_reason_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_reason_r <= R_ENTROPY))
    else $error("reason code out of range");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("verdict without a final request");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r)))
    else $error("stalled input stage lost its request");

endmodule

`default_nettype wire

FILE: hw/rtl/prc_track.sv
// ----------------------------------------------------------------------------
// Password rule checker stream tracker
// Holds the per-password statistics, folds in one byte per step and forms
// the verdict for a final request from the updated statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_track #(
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire prc_pkg::prc_cfg_t               cfg,
  input  wire logic                            step,
  input  wire logic                            has_char,
  input  wire logic [7:0]                      char_byte,
  input  wire logic                            is_last,
  output logic      [prc_pkg::REASON_W-1:0]    reason
);
  import prc_pkg::*;

  localparam int CMP_W = (LENGTH_BITS > LIMIT_W) ? LENGTH_BITS : LIMIT_W;
  localparam int ENT_W = (LENGTH_BITS + 3 > ENTROPY_W) ? LENGTH_BITS + 3 : ENTROPY_W;

  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic [7:0]             prev_r, prev_nxt;
  logic [RUN_W-1:0]       rep_r, rep_nxt;
  logic [RUN_W-1:0]       seq_r, seq_nxt;
  logic [2:0]             seen_r, seen_nxt;
  logic [1:0]             exc_r, exc_nxt;

  logic                   is_cap, is_low, is_dig;
  logic [8:0]             prev_inc;
  logic [ENT_W-1:0]       cnt_ext, entropy;

  assign is_cap   = (char_byte >= 8'h41) && (char_byte <= 8'h5A);
  assign is_low   = (char_byte >= 8'h61) && (char_byte <= 8'h7A);
  assign is_dig   = (char_byte >= 8'h30) && (char_byte <= 8'h39);
  // Sign-extended previous byte plus one; 0x7F then 0x80 does not match.
  assign prev_inc = {prev_r[7], prev_r} + 9'd1;

  always_comb begin
    cnt_nxt  = cnt_r;
    prev_nxt = prev_r;
    rep_nxt  = rep_r;
    seq_nxt  = seq_r;
    seen_nxt = seen_r;
    exc_nxt  = exc_r;
    if (has_char) begin
      seen_nxt[CLS_CAPITAL] = seen_r[CLS_CAPITAL] | is_cap;
      seen_nxt[CLS_DIGIT]   = seen_r[CLS_DIGIT] | is_dig;
      seen_nxt[CLS_SYMBOL]  = seen_r[CLS_SYMBOL] | ~(is_cap | is_low | is_dig);
      if (cnt_r == '0) begin
        rep_nxt = RUN_W'(1);
        seq_nxt = RUN_W'(1);
      end else begin
        if (char_byte == prev_r) begin
          if (rep_r != '1) rep_nxt = rep_r + RUN_W'(1);
        end else begin
          rep_nxt = RUN_W'(1);
        end
        if ({char_byte[7], char_byte} == prev_inc) begin
          if (seq_r != '1) seq_nxt = seq_r + RUN_W'(1);
        end else begin
          seq_nxt = RUN_W'(1);
        end
      end
      if (rep_nxt > cfg.repeat_limit) exc_nxt[EXC_REPEAT] = 1'b1;
      if (seq_nxt > cfg.climb_limit) exc_nxt[EXC_SEQUENCE] = 1'b1;
      prev_nxt = char_byte;
      if (cnt_r != '1) cnt_nxt = cnt_r + LENGTH_BITS'(1);
    end
  end

  // Length times seven, formed as a shift and a subtract.
  assign cnt_ext = ENT_W'(cnt_nxt);
  assign entropy = (cnt_ext << 3) - cnt_ext;

  always_comb begin
    priority if (cfg.check_enable[EN_MIN_LEN] &&
                 (CMP_W'(cnt_nxt) < CMP_W'(cfg.len_floor))) begin
      reason = R_MIN_LEN;
    end else if (cfg.check_enable[EN_MAX_LEN] &&
                 (CMP_W'(cnt_nxt) > CMP_W'(cfg.len_ceiling))) begin
      reason = R_MAX_LEN;
    end else if (cfg.require_classes[CLS_CAPITAL] && !seen_nxt[CLS_CAPITAL]) begin
      reason = R_CAPITAL;
    end else if (cfg.require_classes[CLS_DIGIT] && !seen_nxt[CLS_DIGIT]) begin
      reason = R_DIGIT;
    end else if (cfg.require_classes[CLS_SYMBOL] && !seen_nxt[CLS_SYMBOL]) begin
      reason = R_SYMBOL;
    end else if (cfg.check_enable[EN_REPEAT] && exc_nxt[EXC_REPEAT]) begin
      reason = R_REPEAT;
    end else if (cfg.check_enable[EN_SEQUENCE] && exc_nxt[EXC_SEQUENCE]) begin
      reason = R_SEQUENCE;
    end else if (entropy < ENT_W'(cfg.entropy_floor)) begin
      reason = R_ENTROPY;
    end else begin
      reason = R_PASS;
    end
  end

  // The statistics start over after every verdict.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && is_last)) begin
      cnt_r  <= '0;
      prev_r <= '0;
      rep_r  <= '0;
      seq_r  <= '0;
      seen_r <= '0;
      exc_r  <= '0;
    end else if (step) begin
      cnt_r  <= cnt_nxt;
      prev_r <= prev_nxt;
      rep_r  <= rep_nxt;
      seq_r  <= seq_nxt;
      seen_r <= seen_nxt;
      exc_r  <= exc_nxt;
    end
  end

endmodule

`default_nettype wire
